// ===== src/fbb_pkg.sv =====
// Shared types and constants for the binary frame builder.
package fbb_pkg;

    localparam int DEF_LENGTH_BITS = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    localparam int HDR_BYTES = 24;
    localparam int SUM_BYTES = 4;
    localparam int CNT_W     = $clog2(HDR_BYTES);

    localparam logic [31:0] FRAME_MAGIC   = 32'h4F4A_574D;
    localparam logic [15:0] FRAME_VERSION = 16'h0001;
    localparam logic [15:0] FRAME_FLAGS   = 16'h0000;
    localparam logic [31:0] TYPE_REQUEST  = 32'd1;
    localparam logic [31:0] TYPE_RESPONSE = 32'd2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [63:0] frame_id;
        logic        is_request;
        logic [15:0] frame_len;
        logic [7:0]  data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       error;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_DATA,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t         kind;
        logic [63:0] frame_id;
        logic        is_request;
        logic [31:0] length;
        logic [7:0]  data_byte;
        logic        sum_follows;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic {
        BK_ITEM,
        BK_SUM
    } bk_state_t;

endpackage

// ===== src/binary_frame_builder_top.sv =====
// Binary frame builder: front classifier, request queue and byte sequencer.
// Requests pass through the queue; the back part emits their bytes from its head into
// the output register. A start emits 24 header bytes (28 with zero length), a last
// payload byte 5; the back sequencer emits one byte per cycle when not stalled.
// Reset clears the queue, the open-frame state, the checksum and the output valid.
module binary_frame_builder_top
    import fbb_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  logic req_valid,
    output logic req_stall,
    output rsp_t rsp,
    output logic rsp_valid,
    input  logic rsp_stall
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    entry_t  q_wdata;
    entry_t  q_rdata;

    fbb_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    fbb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .stat  (q_stat)
    );

    fbb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_rdata),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_stat_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |-> !rsp.frame_end && rsp.out_byte == 8'd0)
        else $error("error result carries data");

endmodule

// ===== src/fbb_queue.sv =====
// Small register queue between the front and back parts.
module fbb_queue
    import fbb_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  wdata,
    input  logic    pop,
    output entry_t  rdata,
    output q_stat_t stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/fbb_front.sv =====
// Front part: accepts requests, tracks the open frame and classifies each request.
module fbb_front
    import fbb_pkg::*;
#(
    parameter int LENGTH_BITS = DEF_LENGTH_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    input  logic    req_valid,
    output logic    req_stall,
    input  q_stat_t q_stat,
    output logic    q_push,
    output entry_t  q_wdata
);

    logic                    frame_open_reg;
    logic                    frame_open_next;
    logic [LENGTH_BITS-1:0]  bytes_left_reg;
    logic [LENGTH_BITS-1:0]  bytes_left_next;
    logic [LENGTH_BITS+15:0] len_wide;
    logic [LENGTH_BITS-1:0]  len_cut;
    logic [LENGTH_BITS-1:0]  left_dec;

    assign req_stall = q_stat.full;
    assign q_push    = req_valid && !q_stat.full;

    always_comb
    begin
        len_wide        = {LENGTH_BITS'(1'b0), req.frame_len};
        len_cut         = len_wide[LENGTH_BITS-1:0];
        left_dec        = bytes_left_reg - LENGTH_BITS'(1);
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;

        q_wdata.kind        = OP_ERROR;
        q_wdata.frame_id    = req.frame_id;
        q_wdata.is_request  = req.is_request;
        q_wdata.length      = 32'(len_cut);
        q_wdata.data_byte   = req.data_byte;
        q_wdata.sum_follows = 1'b0;

        if (req.command == CMD_START)
        begin
            q_wdata.kind        = OP_START;
            q_wdata.sum_follows = (len_cut == '0);
            frame_open_next     = (len_cut != '0);
            bytes_left_next     = len_cut;
        end
        else if (frame_open_reg)
        begin
            q_wdata.kind        = OP_DATA;
            q_wdata.sum_follows = (left_dec == '0);
            frame_open_next     = (left_dec != '0);
            bytes_left_next     = left_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else if (q_push)
        begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ===== src/fbb_back.sv =====
// Back part: emits header, payload, checksum and error bytes into the output register.
module fbb_back
    import fbb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  head,
    input  q_stat_t q_stat,
    output logic    q_pop,
    output rsp_t    rsp,
    output logic    rsp_valid,
    input  logic    rsp_stall
);

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [31:0]        crc_reg;
    logic [31:0]        crc_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               load_ok;
    logic               emit;
    logic [31:0]        crc_base;
    logic [31:0]        crc_mix;
    logic [7:0]         cur_byte;
    logic [191:0]       hdr_vec;
    logic [7:0]         hdr_bytes [HDR_BYTES];

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        hdr_vec = {head.length, head.frame_id,
                   head.is_request ? TYPE_REQUEST : TYPE_RESPONSE,
                   FRAME_FLAGS, FRAME_VERSION, FRAME_MAGIC};
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            hdr_bytes[i] = hdr_vec[i*8 +: 8];
        end
    end

    always_comb
    begin
        load_ok    = !rsp_valid_reg || !rsp_stall;
        emit       = 1'b0;
        q_pop      = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        rsp_next   = rsp_reg;
        crc_base   = crc_reg;
        cur_byte   = head.data_byte;

        case (state_reg)
            BK_ITEM:
            begin
                if (head.kind == OP_START)
                begin
                    cur_byte = hdr_bytes[cnt_reg];
                    crc_base = (cnt_reg == '0) ? 32'd0 : crc_reg;
                end
                crc_mix = crc_base ^ {24'd0, cur_byte};
                if (load_ok && !q_stat.empty)
                begin
                    emit = 1'b1;
                    case (head.kind)
                        OP_START:
                        begin
                            rsp_next = '{out_byte: cur_byte, frame_end: 1'b0, error: 1'b0};
                            crc_next = {crc_mix[30:0], crc_mix[31]};
                            if (cnt_reg == CNT_W'(HDR_BYTES - 1))
                            begin
                                q_pop    = 1'b1;
                                cnt_next = '0;
                                if (head.sum_follows)
                                begin
                                    state_next = BK_SUM;
                                end
                            end
                            else
                            begin
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_DATA:
                        begin
                            rsp_next = '{out_byte: cur_byte, frame_end: 1'b0, error: 1'b0};
                            crc_next = {crc_mix[30:0], crc_mix[31]};
                            q_pop    = 1'b1;
                            if (head.sum_follows)
                            begin
                                state_next = BK_SUM;
                            end
                        end
                        default:
                        begin
                            rsp_next = '{out_byte: 8'd0, frame_end: 1'b0, error: 1'b1};
                            q_pop    = 1'b1;
                        end
                    endcase
                end
            end
            BK_SUM:
            begin
                crc_mix = crc_reg;
                if (load_ok)
                begin
                    emit     = 1'b1;
                    rsp_next = '{out_byte: crc_reg[cnt_reg[1:0]*8 +: 8],
                                 frame_end: (cnt_reg == CNT_W'(SUM_BYTES - 1)),
                                 error: 1'b0};
                    if (cnt_reg == CNT_W'(SUM_BYTES - 1))
                    begin
                        cnt_next   = '0;
                        state_next = BK_ITEM;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                crc_mix    = crc_reg;
                state_next = BK_ITEM;
                cnt_next   = '0;
            end
        endcase

        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_ITEM;
            cnt_reg       <= '0;
            crc_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            crc_reg       <= crc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule
